@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ hdl/shs_pkg.sv @@
`default_nettype none

package shs_pkg;

	localparam int BYTE_TOTAL_W = 61;
	localparam int LEN_W        = 64;
	localparam logic [31:0] PAD_MARK = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_of_digest;
	} dig_t;

	// Padding description of one block: words below limit come from the buffer.
	typedef struct packed {
		logic [4:0] limit;
		logic       mark_vld;
		logic [3:0] mark_idx;
		logic       len_vld;
	} pad_t;

	typedef struct packed {
		logic       rd_en;
		logic [3:0] rd_addr;
		logic       shift_en;
		logic [3:0] idx;
		logic       use_mem;
	} sch_ctl_t;

	typedef struct packed {
		logic       rd_en;
		logic [2:0] rd_addr;
		logic       load_shift;
		logic       round_en;
		logic [5:0] round_idx;
		logic       wb_en;
		logic [2:0] wb_addr;
		logic       clr;
	} rnd_ctl_t;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	// Final word: keep the used bytes, then the 0x80 marker if it fits.
	function automatic logic [31:0] final_word(input logic [31:0] d, input logic [2:0] nv);
		logic [31:0] r;
		case (nv)
			3'd0:    r = PAD_MARK;
			3'd1:    r = {d[31:24], 8'h80, 16'h0000};
			3'd2:    r = {d[31:16], 8'h80, 8'h00};
			3'd3:    r = {d[31:8], 8'h80};
			default: r = d;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0:    r = 32'h6A09E667;
			3'd1:    r = 32'hBB67AE85;
			3'd2:    r = 32'h3C6EF372;
			3'd3:    r = 32'hA54FF53A;
			3'd4:    r = 32'h510E527F;
			3'd5:    r = 32'h9B05688C;
			3'd6:    r = 32'h1F83D9AB;
			default: r = 32'h5BE0CD19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0:  r = 32'h428A2F98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hB5C0FBCF; 6'd3:  r = 32'hE9B5DBA5;
			6'd4:  r = 32'h3956C25B; 6'd5:  r = 32'h59F111F1;
			6'd6:  r = 32'h923F82A4; 6'd7:  r = 32'hAB1C5ED5;
			6'd8:  r = 32'hD807AA98; 6'd9:  r = 32'h12835B01;
			6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
			6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE;
			6'd14: r = 32'h9BDC06A7; 6'd15: r = 32'hC19BF174;
			6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
			6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC;
			6'd20: r = 32'h2DE92C6F; 6'd21: r = 32'h4A7484AA;
			6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
			6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D;
			6'd26: r = 32'hB00327C8; 6'd27: r = 32'hBF597FC7;
			6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
			6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27B70A85; 6'd33: r = 32'h2E1B2138;
			6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
			6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB;
			6'd38: r = 32'h81C2C92E; 6'd39: r = 32'h92722C85;
			6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
			6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3;
			6'd44: r = 32'hD192E819; 6'd45: r = 32'hD6990624;
			6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
			6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08;
			6'd50: r = 32'h2748774C; 6'd51: r = 32'h34B0BCB5;
			6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
			6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3;
			6'd56: r = 32'h748F82EE; 6'd57: r = 32'h78A5636F;
			6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
			6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB;
			6'd62: r = 32'hBEF9A3F7;
			default: r = 32'hC67178F2;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/sha256_stream_hasher_core.sv @@
// SHA-256 over a stream of big-endian 32-bit words. A word that does not end
// the message is accepted with no hold-off, except the sixteenth word of a
// block, after which the input is held off while the block is compressed: the
// eight chaining words are read out of their memory, 64 rounds run at one per
// cycle, and the chain is added and written back. The final word takes one or
// two such compressions (two when the padding does not leave room for the
// length), then the eight digest words are read from the chaining memory one
// at a time, each waiting in the output register for its transfer; the next
// message is taken as soon as the last word is loaded there. The sustained
// rate is set by the single round unit and the serial load and write-back of
// the chaining words.
`default_nettype none

`include "assert_macros.svh"

module sha256_stream_hasher_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          msg_valid,
	output logic               msg_ready,
	input  wire shs_pkg::msg_t msg,
	output logic               dig_valid,
	input  wire logic          dig_ready,
	output shs_pkg::dig_t      dig
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_WB    = 3'd3;
	localparam logic [2:0] ST_ORD   = 3'd4;
	localparam logic [2:0] ST_OCAP  = 3'd5;

	logic [2:0]                       state_q;
	logic [6:0]                       cnt_q;
	logic [3:0]                       fill_q;
	logic [shs_pkg::BYTE_TOTAL_W-1:0] total_q;
	logic                             final_q;
	logic                             blk2_q;
	logic [2:0]                       oidx_q;
	logic                             out_vld_q;
	shs_pkg::dig_t                    out_q;
	shs_pkg::pad_t                    pad_q;
	shs_pkg::pad_t                    pad2_q;
	logic [shs_pkg::LEN_W-1:0]        len_q;

	logic                             acc;
	logic [2:0]                       nv_sat;
	logic                             nv4;
	logic [shs_pkg::BYTE_TOTAL_W-1:0] total_fin;
	shs_pkg::pad_t                    pad1_d;
	shs_pkg::pad_t                    pad2_d;
	shs_pkg::pad_t                    pad_full;
	logic                             out_free;
	logic [31:0]                      blk_wdata;
	logic [31:0]                      w;
	logic [31:0]                      chain_data;
	shs_pkg::sch_ctl_t                sch_ctl;
	shs_pkg::rnd_ctl_t                rnd_ctl;

	assign msg_ready = (state_q == ST_IDLE);
	assign acc       = msg_valid && msg_ready;
	assign dig_valid = out_vld_q;
	assign dig       = out_q;
	assign out_free  = !out_vld_q || dig_ready;

	assign nv_sat    = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
	assign nv4       = (nv_sat == 3'd4);
	assign total_fin = total_q + {{(shs_pkg::BYTE_TOTAL_W-3){1'b0}}, nv_sat};
	assign blk_wdata = msg.last_word ? shs_pkg::final_word(msg.data_word, nv_sat)
		: msg.data_word;

	always_comb begin
		pad1_d.limit    = {1'b0, fill_q} + 5'd1;
		pad1_d.mark_vld = nv4 && (fill_q != 4'd15);
		pad1_d.mark_idx = fill_q + 4'd1;
		pad1_d.len_vld  = nv4 ? (fill_q <= 4'd12) : (fill_q <= 4'd13);
		pad2_d.limit    = 5'd0;
		pad2_d.mark_vld = nv4 && (fill_q == 4'd15);
		pad2_d.mark_idx = 4'd0;
		pad2_d.len_vld  = 1'b1;
		pad_full.limit    = 5'd16;
		pad_full.mark_vld = 1'b0;
		pad_full.mark_idx = 4'd0;
		pad_full.len_vld  = 1'b0;
	end

	always_comb begin
		sch_ctl.rd_en    = 1'b0;
		sch_ctl.rd_addr  = 4'd0;
		sch_ctl.shift_en = (state_q == ST_ROUND);
		sch_ctl.idx      = cnt_q[3:0];
		sch_ctl.use_mem  = (cnt_q < 7'd16);
		if (state_q == ST_LOAD && cnt_q == 7'd8) begin
			sch_ctl.rd_en = 1'b1;
		end else if (state_q == ST_ROUND && cnt_q < 7'd15) begin
			sch_ctl.rd_en   = 1'b1;
			sch_ctl.rd_addr = cnt_q[3:0] + 4'd1;
		end
	end

	always_comb begin
		rnd_ctl.rd_en      = 1'b0;
		rnd_ctl.rd_addr    = cnt_q[2:0];
		rnd_ctl.load_shift = (state_q == ST_LOAD) && (cnt_q != 7'd0);
		rnd_ctl.round_en   = (state_q == ST_ROUND);
		rnd_ctl.round_idx  = cnt_q[5:0];
		rnd_ctl.wb_en      = (state_q == ST_WB) && (cnt_q != 7'd0);
		rnd_ctl.wb_addr    = cnt_q[2:0] - 3'd1;
		rnd_ctl.clr        = (state_q == ST_OCAP) && (oidx_q == 3'd7);
		if ((state_q == ST_LOAD || state_q == ST_WB) && cnt_q < 7'd8) begin
			rnd_ctl.rd_en = 1'b1;
		end else if (state_q == ST_ORD && out_free) begin
			rnd_ctl.rd_en   = 1'b1;
			rnd_ctl.rd_addr = oidx_q;
		end
	end

	shs_sched u_sched (
		.clk      (clk),
		.ctl      (sch_ctl),
		.wr_en    (acc),
		.wr_addr  (fill_q),
		.wr_data  (blk_wdata),
		.pad      (pad_q),
		.len_bits (len_q),
		.w        (w)
	);

	shs_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (rnd_ctl),
		.w          (w),
		.chain_data (chain_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			final_q   <= 1'b0;
			blk2_q    <= 1'b0;
			oidx_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (dig_valid && dig_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_q <= '0;
						if (msg.last_word) begin
							fill_q  <= '0;
							total_q <= '0;
							final_q <= 1'b1;
							blk2_q  <= !pad1_d.len_vld;
							state_q <= ST_LOAD;
						end else begin
							fill_q  <= fill_q + 4'd1;
							total_q <= total_q + {{(shs_pkg::BYTE_TOTAL_W-3){1'b0}}, 3'd4};
							final_q <= 1'b0;
							blk2_q  <= 1'b0;
							if (fill_q == 4'd15) begin
								state_q <= ST_LOAD;
							end
						end
					end
				end
				ST_LOAD: begin
					if (cnt_q == 7'd8) begin
						cnt_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_ROUND: begin
					if (cnt_q == 7'd63) begin
						cnt_q   <= '0;
						state_q <= ST_WB;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_WB: begin
					if (cnt_q == 7'd8) begin
						cnt_q <= '0;
						if (blk2_q) begin
							blk2_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else if (final_q) begin
							oidx_q  <= '0;
							state_q <= ST_ORD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_ORD: begin
					if (out_free) begin
						state_q <= ST_OCAP;
					end
				end
				ST_OCAP: begin
					out_vld_q <= 1'b1;
					if (oidx_q == 3'd7) begin
						final_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						oidx_q  <= oidx_q + 3'd1;
						state_q <= ST_ORD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (msg.last_word) begin
				pad_q  <= pad1_d;
				pad2_q <= pad2_d;
				len_q  <= {total_fin, 3'b000};
			end else begin
				pad_q <= pad_full;
			end
		end else if (state_q == ST_WB && cnt_q == 7'd8 && blk2_q) begin
			pad_q <= pad2_q;
		end
		if (state_q == ST_OCAP) begin
			out_q.digest_word    <= chain_data;
			out_q.word_index     <= oidx_q;
			out_q.last_of_digest <= (oidx_q == 3'd7);
		end
	end

	`ASSERT_NEVER(a_out_overwrite, (state_q == ST_OCAP) && dig_valid, "digest register overwritten before transfer")
	`ASSERT_CLK(a_round_to_wb, (state_q == ST_ROUND) && (cnt_q == 7'd63) |=> (state_q == ST_WB), "round count did not end in write-back")
	`ASSERT_CLK(a_final_starts, acc && msg.last_word |=> (state_q == ST_LOAD) && (fill_q == 4'd0), "final word did not start compression")
	`ASSERT_CLK(a_last_flag, dig_valid |-> (dig.last_of_digest == (dig.word_index == 3'd7)), "last flag does not match word index")
	`ASSERT_CLK(a_wrap_compress, acc && !msg.last_word && (fill_q == 4'd15) |=> (state_q == ST_LOAD), "full block not compressed")

endmodule

`default_nettype wire

@@ hdl/shs_sched.sv @@
`default_nettype none

// Block buffer memory and message schedule window.
module shs_sched (
	input  wire logic                clk,
	input  wire shs_pkg::sch_ctl_t   ctl,
	input  wire logic                wr_en,
	input  wire logic [3:0]          wr_addr,
	input  wire logic [31:0]         wr_data,
	input  wire shs_pkg::pad_t       pad,
	input  wire logic [63:0]         len_bits,
	output logic [31:0]              w
);

	logic [31:0] mem [16];
	logic [31:0] rd_q;
	logic [31:0] win_q [16];
	logic [31:0] gen_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[ctl.rd_addr];
		end
	end

	always_comb begin
		if ({1'b0, ctl.idx} < pad.limit) begin
			gen_word = rd_q;
		end else if (pad.mark_vld && (ctl.idx == pad.mark_idx)) begin
			gen_word = shs_pkg::PAD_MARK;
		end else if (pad.len_vld && (ctl.idx == 4'd14)) begin
			gen_word = len_bits[63:32];
		end else if (pad.len_vld && (ctl.idx == 4'd15)) begin
			gen_word = len_bits[31:0];
		end else begin
			gen_word = '0;
		end
	end

	always_comb begin
		if (ctl.use_mem) begin
			w = gen_word;
		end else begin
			w = win_q[0] + shs_pkg::ssig0(win_q[1]) + win_q[9] + shs_pkg::ssig1(win_q[14]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w;
		end
	end

endmodule

`default_nettype wire

@@ hdl/shs_round.sv @@
`default_nettype none

// Chaining memory and the round datapath.
module shs_round (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire shs_pkg::rnd_ctl_t  ctl,
	input  wire logic [31:0]        w,
	output logic [31:0]             chain_data
);

	logic [31:0] mem [8];
	logic [31:0] rd_q;
	logic        rd_vld_q;
	logic [2:0]  rd_addr_q;
	logic [7:0]  vld_q;
	logic [31:0] v_q [8];
	logic [31:0] t1;
	logic [31:0] t2;

	assign chain_data = rd_vld_q ? rd_q : shs_pkg::init_h(rd_addr_q);

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q      <= mem[ctl.rd_addr];
			rd_vld_q  <= vld_q[ctl.rd_addr];
			rd_addr_q <= ctl.rd_addr;
		end
		if (ctl.wb_en) begin
			mem[ctl.wb_addr] <= chain_data + v_q[0];
		end
	end

	// Entries not yet written since the last digest read as the initial hash.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.clr) begin
			vld_q <= '0;
		end else if (ctl.wb_en) begin
			vld_q[ctl.wb_addr] <= 1'b1;
		end
	end

	always_comb begin
		t1 = v_q[7] + shs_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ shs_pkg::round_k(ctl.round_idx) + w;
		t2 = shs_pkg::bsig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (ctl.load_shift) begin
			for (int i = 0; i < 7; i++) begin
				v_q[i] <= v_q[i + 1];
			end
			v_q[7] <= chain_data;
		end else if (ctl.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (ctl.wb_en) begin
			for (int i = 0; i < 7; i++) begin
				v_q[i] <= v_q[i + 1];
			end
			v_q[7] <= v_q[0];
		end
	end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 130;

	localparam logic [0:7][31:0] SHA_IV = {
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [0:63][31:0] SHA_K = {
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_ready;
	shs_pkg::msg_t msg = '0;
	logic dig_valid;
	logic dig_ready = 1'b0;
	shs_pkg::dig_t dig;

	logic [31:0] hash_state [8];
	logic [31:0] block_buf [16];
	logic [60:0] msg_bytes;
	logic [3:0]  word_slot;
	shs_pkg::dig_t digest_q [$];

	int errors = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;

	sha256_stream_hasher_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_restart();
		for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
		for (int i = 0; i < 16; i++) block_buf[i] = '0;
		msg_bytes = '0;
		word_slot = '0;
	endfunction

	function automatic void sha_compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++) w[i] = block_buf[i];
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
	endfunction

	function automatic void put_msg_byte(input int unsigned p, input logic [7:0] b);
		block_buf[(p >> 2) & 15][31 - 8 * (p & 3) -: 8] = b;
	endfunction

	// Fold one accepted word into the running hash; queue the digest on the final word.
	function automatic void sha_absorb(input shs_pkg::msg_t m);
		int unsigned nv;
		int unsigned pos;
		logic [63:0] bit_len;
		shs_pkg::dig_t d;
		if (!m.last_word) begin
			block_buf[word_slot] = m.data_word;
			msg_bytes = msg_bytes + 61'd4;
			word_slot = word_slot + 4'd1;
			if (word_slot == 4'd0)
				sha_compress();
			return;
		end
		nv = (m.valid_bytes > 3'd4) ? 32'd4 : {29'd0, m.valid_bytes};
		msg_bytes = msg_bytes + 61'(nv);
		for (int i = int'(word_slot); i < 16; i++) block_buf[i] = '0;
		pos = 4 * {28'd0, word_slot};
		for (int i = 0; i < nv; i++) put_msg_byte(pos + i, m.data_word[31 - 8 * i -: 8]);
		pos = pos + nv;
		if (pos >= 64) begin
			sha_compress();
			for (int i = 0; i < 16; i++) block_buf[i] = '0;
			pos = 0;
		end
		put_msg_byte(pos, 8'h80);
		pos = pos + 1;
		if (pos > 56) begin
			sha_compress();
			for (int i = 0; i < 16; i++) block_buf[i] = '0;
		end
		bit_len = {msg_bytes, 3'b000};
		block_buf[14] = bit_len[63:32];
		block_buf[15] = bit_len[31:0];
		sha_compress();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = hash_state[i];
			d.word_index = 3'(i);
			d.last_of_digest = (i == 7);
			digest_q.push_back(d);
		end
		sha_restart();
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_word(input logic [31:0] data, input logic [2:0] nv, input logic last);
		shs_pkg::msg_t m;
		m.data_word = data;
		m.valid_bytes = nv;
		m.last_word = last;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 11) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg <= m;
		msg_valid <= 1'b1;
		do @(posedge clk); while (!msg_ready);
		sha_absorb(m);
		items_sent++;
	endtask

	task automatic drain_digests();
		@(negedge clk);
		msg_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
	endtask

	task automatic send_message(input int words);
		for (int i = 0; i < words; i++)
			send_word($urandom, 3'($urandom_range(7)), 1'b0);
		send_word($urandom, 3'($urandom_range(7)), 1'b1);
	endtask

	task automatic test_short_messages();
		send_word(32'h0000_0000, 3'd0, 1'b1);
		send_word(32'h6162_6300, 3'd3, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		send_word(32'h00FF_FFFF, 3'd1, 1'b1);
		// counts above four saturate
		send_word(32'hA5A5_A5A5, 3'd5, 1'b1);
		send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
		send_word(32'h1234_5678, 3'd7, 1'b1);
		// count on a non-final word is ignored
		send_word(32'hDEAD_BEEF, 3'd7, 1'b0);
		send_word(32'h0000_0000, 3'd2, 1'b1);
	endtask

	task automatic test_full_final_block();
		for (int i = 0; i < 15; i++)
			send_word($urandom, 3'($urandom_range(7)), 1'b0);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
	endtask

	task automatic test_random_messages();
		int n_msgs;
		int blocks;
		int pick;
		n_msgs = 0;
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(9);
			blocks = (pick < 6) ? 0 : (pick < 9) ? 1 : 2;
			no_idle = (n_msgs >= 3 && n_msgs <= 5);
			send_message(16 * blocks + $urandom_range(15));
			n_msgs++;
			if (n_msgs == 1)
				drain_digests();
		end
		no_idle = 1'b0;
	endtask

	always @(negedge clk) begin
		dig_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 11);
	end

	always @(posedge clk) begin
		shs_pkg::dig_t want;
		if (arst_n && dig_valid && dig_ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t: digest word %h with none expected", $realtime, dig.digest_word);
				errors++;
			end else begin
				want = digest_q.pop_front();
				if (dig.digest_word !== want.digest_word)
					report_mismatch("digest_word", dig.digest_word, want.digest_word);
				if (dig.word_index !== want.word_index)
					report_mismatch("word_index", 32'(dig.word_index), 32'(want.word_index));
				if (dig.last_of_digest !== want.last_of_digest)
					report_mismatch("last_of_digest", 32'(dig.last_of_digest),
						32'(want.last_of_digest));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_valid && msg_ready) || (dig_valid && dig_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		sha_restart();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_short_messages();
		test_full_final_block();
		test_random_messages();
		drain_digests();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
